// ----- design/ccs_pkg.sv -----
// Shared types, widths and constants for the coulomb counter block.
// Used by every design module of the block but the checker; depends on nothing else.
package ccs_pkg;

    // field and register widths
    localparam int CurW   = 19;  // signed pack current, mA
    localparam int MsW    = 16;  // elapsed time, ms
    localparam int CapW   = 17;  // capacity, mAh
    localparam int EffW   = 16;  // efficiency, Q0.16
    localparam int ThrW   = 14;  // idle, full and empty thresholds
    localparam int SocW   = 14;  // soc and soh, hundredths of a percent
    localparam int CntW   = 16;  // half-cycle counter
    localparam int IdxW   = 3;   // register index
    localparam int DataW  = 17;  // widest register

    // datapath widths
    localparam int HourW  = 22;             // width of ms per hour
    localparam int PerW   = 9;              // width of mA*ms per ten-thousandth of a mAh
    localparam int UnitsW = CapW + HourW;   // capacity in mA*ms
    localparam int DivW   = CapW + PerW;    // capacity in mA*ms per hundredth of a percent
    localparam int StoreW = UnitsW + 1;     // charge store plus one tick before clamp
    localparam int MagW   = CurW + MsW;     // |current| * time
    localparam int HiW    = MagW + 1;       // upper half of the shift-add product
    localparam int AluW   = StoreW + 1;     // shared adder width
    localparam int MulSteps = MsW;          // one multiplier bit per cycle
    localparam int DivSteps = SocW;         // one quotient bit per cycle
    localparam int StepW  = 4;

    localparam logic [HourW-1:0] MS_PER_HOUR   = 22'd3600000;
    localparam logic [PerW-1:0]  UNITS_PER_HUN = 9'd360;
    localparam logic [SocW-1:0]  FULL_SCALE    = 14'd10000;

    // reset values
    localparam logic [CapW-1:0]   CAP_RST   = 17'd2000;
    localparam logic [UnitsW-1:0] UNITS_RST = 39'd7200000000;
    localparam logic [DivW-1:0]   DIV_RST   = 26'd720000;
    localparam logic [StoreW-1:0] STORE_RST = 40'd3600000000;
    localparam logic [EffW-1:0]   EFF_RST   = 16'd62259;
    localparam logic [ThrW-1:0]   IDLE_RST  = 14'd50;
    localparam logic [ThrW-1:0]   FULL_RST  = 14'd9500;
    localparam logic [ThrW-1:0]   EMPTY_RST = 14'd500;

    typedef enum logic [IdxW-1:0] {
        REG_CAPACITY   = 3'd0,
        REG_EFFICIENCY = 3'd1,
        REG_IDLE_THR   = 3'd2,
        REG_FULL_THR   = 3'd3,
        REG_EMPTY_THR  = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_TIME,
        ST_MUL_EFF,
        ST_ADD,
        ST_CLAMP,
        ST_DIV,
        ST_EVAL
    } state_t;

    typedef struct packed {
        logic [CapW-1:0]   cap_mah;
        logic [UnitsW-1:0] cap_units;
        logic [DivW-1:0]   divisor;
        logic [EffW-1:0]   eff;
        logic [ThrW-1:0]   idle_thr;
        logic [ThrW-1:0]   full_thr;
        logic [ThrW-1:0]   empty_thr;
        logic              reload;
    } cfg_t;

    typedef struct packed {
        logic [SocW-1:0] soc;
        logic [SocW-1:0] soh;
        logic            charging;
        logic [CntW-1:0] half_cycles;
        logic            cycle_event;
    } result_t;

    // health: 100.00% minus 0.05% per half cycle, floored at zero
    function automatic logic [SocW-1:0] soh_of(input logic [CntW-1:0] count);
        logic [CntW+2:0] dec;
        logic [CntW+2:0] dec_rem;
        dec = {count, 2'b00} + {3'b000, count};
        dec_rem = {5'b00000, FULL_SCALE} - dec;
        if (dec >= {5'b00000, FULL_SCALE})
            soh_of = '0;
        else
            soh_of = dec_rem[SocW-1:0];
    endfunction

endpackage

// ----- design/coulomb_counter_soc_soh.sv -----
// Coulomb counter with state of charge and cycle-based state of health.
// m_tvalid rises once a request has run through the whole sequence, which takes
// longer when charging (extra efficiency multiply); a new request is taken
// only once the core is idle again, as the single shared adder steps through
// one or two shift-add multiplies and a 14-step division.
// Reset (rst_n, asynchronous) restores the default registers and half charge.
module coulomb_counter_soc_soh
    import ccs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,

    // slave side: one tick request
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [39:0]      s_tdata,   // pack_current_ma[18:0], elapsed_ms[34:19], zero pad

    // master side: one result per tick
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [47:0]      m_tdata,   // soc_hundredths[13:0], soh_hundredths[27:14],
                                        // charging[28], half_cycles[44:29],
                                        // cycle_event[45], zero pad

    // configuration write port
    input  logic             wr_en,
    input  logic [IdxW-1:0]  wr_addr,
    input  logic [DataW-1:0] wr_data
);

    cfg_t    cfg;
    result_t res;
    logic    res_valid;
    logic    res_ready;

    // Output register: a finished result waits here so the core can take the
    // next request while the master side stalls.
    logic    out_valid_reg;
    result_t out_data_reg;

    ccs_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .cfg     (cfg)
    );

    // The core runs the sequence multiply (|current| x time), optional
    // efficiency multiply, signed update of the charge store, clamp to
    // capacity, then a restoring division for the soc quotient, all through
    // one adder. It accepts a request only while idle.
    ccs_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_cur    (s_tdata[CurW-1:0]),
        .in_ms     (s_tdata[CurW+MsW-1:CurW]),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    // Free when empty or being drained this cycle.
    assign res_ready = !out_valid_reg || m_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (res_valid && res_ready)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    // Payload needs no reset; load it with the result.
    always_ff @(posedge clk)
    begin
        if (res_valid && res_ready)
            out_data_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {2'b00,
                       out_data_reg.cycle_event,
                       out_data_reg.half_cycles,
                       out_data_reg.charging,
                       out_data_reg.soh,
                       out_data_reg.soc};

endmodule

// ----- design/ccs_addsub.sv -----
// Shared add/subtract unit of the coulomb counter datapath.
// Depends on ccs_pkg for the adder width.
module ccs_addsub
    import ccs_pkg::*;
(
    input  logic [AluW-1:0] a,
    input  logic [AluW-1:0] b,
    input  logic            sub,
    output logic [AluW-1:0] res,
    output logic            carry
);

    logic [AluW:0] sum;

    // subtract as a plus inverted b plus one; carry set means a >= b
    assign sum   = {1'b0, a} + {1'b0, (sub ? ~b : b)} + {{AluW{1'b0}}, sub};
    assign res   = sum[AluW-1:0];
    assign carry = sum[AluW];

endmodule

// ----- design/ccs_cfg.sv -----
// Configuration registers of the coulomb counter, with derived capacity terms.
// Depends on ccs_pkg for widths, register indexes and reset values.
module ccs_cfg
    import ccs_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [IdxW-1:0]  wr_addr,
    input  logic [DataW-1:0] wr_data,
    output cfg_t             cfg
);

    logic [CapW-1:0]   cap_mah_reg;
    logic [UnitsW-1:0] cap_units_reg;
    logic [DivW-1:0]   divisor_reg;
    logic [EffW-1:0]   eff_reg;
    logic [ThrW-1:0]   idle_reg;
    logic [ThrW-1:0]   full_reg;
    logic [ThrW-1:0]   empty_reg;
    logic              reload_reg;

    logic [CapW-1:0]   cap_w;
    logic [UnitsW-1:0] units_w;
    logic [DivW-1:0]   div_w;
    logic              cap_write;

    assign cap_w     = wr_data[CapW-1:0];
    assign cap_write = wr_en && (wr_addr == REG_CAPACITY);
    assign units_w   = {{(UnitsW-CapW){1'b0}}, cap_w} * {{(UnitsW-HourW){1'b0}}, MS_PER_HOUR};
    assign div_w     = {{(DivW-CapW){1'b0}}, cap_w} * {{(DivW-PerW){1'b0}}, UNITS_PER_HUN};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cap_mah_reg   <= CAP_RST;
            cap_units_reg <= UNITS_RST;
            divisor_reg   <= DIV_RST;
            eff_reg       <= EFF_RST;
            idle_reg      <= IDLE_RST;
            full_reg      <= FULL_RST;
            empty_reg     <= EMPTY_RST;
            reload_reg    <= 1'b0;
        end
        else
        begin
            // register the charge reload request alongside the new units, so the reload sees them in place
            reload_reg <= cap_write;
            if (wr_en)
            begin
                case (wr_addr)
                    REG_CAPACITY:
                    begin
                        cap_mah_reg   <= cap_w;
                        cap_units_reg <= units_w;
                        divisor_reg   <= div_w;
                    end
                    REG_EFFICIENCY: eff_reg   <= wr_data[EffW-1:0];
                    REG_IDLE_THR:   idle_reg  <= wr_data[ThrW-1:0];
                    REG_FULL_THR:   full_reg  <= wr_data[ThrW-1:0];
                    REG_EMPTY_THR:  empty_reg <= wr_data[ThrW-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb
    begin
        cfg.cap_mah   = cap_mah_reg;
        cfg.cap_units = cap_units_reg;
        cfg.divisor   = divisor_reg;
        cfg.eff       = eff_reg;
        cfg.idle_thr  = idle_reg;
        cfg.full_thr  = full_reg;
        cfg.empty_thr = empty_reg;
        cfg.reload    = reload_reg;
    end

endmodule

// ----- design/ccs_core.sv -----
// Sequencer and datapath registers of the coulomb counter: multiply, update,
// clamp and divide through one shared adder. Depends on ccs_pkg, ccs_addsub.
module ccs_core
    import ccs_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  cfg_t            cfg,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [CurW-1:0] in_cur,
    input  logic [MsW-1:0]  in_ms,
    output logic            res_valid,
    input  logic            res_ready,
    output result_t         res
);

    localparam logic [StepW-1:0] MUL_LAST = StepW'(MulSteps - 1);
    localparam logic [StepW-1:0] DIV_LAST = StepW'(DivSteps - 1);

    state_t            state_reg, state_next;
    logic [StepW-1:0]  step_reg, step_next;
    logic              neg_reg, neg_next;
    logic              pos_reg, pos_next;
    logic [HiW-1:0]    hi_reg, hi_next;
    logic [MsW-1:0]    lo_reg, lo_next;
    logic [MagW-1:0]   mcand_reg, mcand_next;
    logic [StoreW-1:0] store_reg, store_next;
    logic [StoreW-1:0] rem_reg, rem_next;
    logic [StoreW-1:0] dsh_reg, dsh_next;
    logic [SocW-1:0]   quo_reg, quo_next;
    logic [CntW-1:0]   count_reg, count_next;
    logic              seen_full_reg, seen_full_next;
    logic              seen_empty_reg, seen_empty_next;
    logic              chg_reg, chg_next;

    logic [AluW-1:0]   alu_a, alu_b, alu_res;
    logic              alu_sub, alu_carry;

    logic signed [CurW-1:0] cur_s, thr_s;
    logic [CurW-1:0]   cur_abs;
    logic [HiW-1:0]    mul_hi;
    logic [MsW-1:0]    mul_lo;
    logic [StoreW-1:0] clamped;
    logic [SocW-1:0]   soc;
    logic              sf, se;

    ccs_addsub u_alu (
        .a     (alu_a),
        .b     (alu_b),
        .sub   (alu_sub),
        .res   (alu_res),
        .carry (alu_carry)
    );

    assign cur_s   = $signed(in_cur);
    assign thr_s   = $signed({{(CurW-ThrW){1'b0}}, cfg.idle_thr});
    assign cur_abs = in_cur[CurW-1] ? (~in_cur + CurW'(1)) : in_cur;

    // one shift-add step: product register {hi, lo} shifts right by one
    assign mul_hi  = {1'b0, alu_res[HiW-1:1]};
    assign mul_lo  = {alu_res[0], lo_reg[MsW-1:1]};
    assign clamped = alu_carry ? {{(StoreW-UnitsW){1'b0}}, cfg.cap_units} : store_reg;
    assign soc     = (cfg.cap_mah == '0) ? '0 : quo_reg;
    assign sf      = seen_full_reg || (soc >= cfg.full_thr);
    assign se      = seen_empty_reg || (soc <= cfg.empty_thr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            store_reg      <= STORE_RST;
            count_reg      <= '0;
            seen_full_reg  <= 1'b0;
            seen_empty_reg <= 1'b0;
            chg_reg        <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            store_reg      <= store_next;
            count_reg      <= count_next;
            seen_full_reg  <= seen_full_next;
            seen_empty_reg <= seen_empty_next;
            chg_reg        <= chg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        step_reg  <= step_next;
        neg_reg   <= neg_next;
        pos_reg   <= pos_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        mcand_reg <= mcand_next;
        rem_reg   <= rem_next;
        dsh_reg   <= dsh_next;
        quo_reg   <= quo_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        step_next       = step_reg;
        neg_next        = neg_reg;
        pos_next        = pos_reg;
        hi_next         = hi_reg;
        lo_next         = lo_reg;
        mcand_next      = mcand_reg;
        store_next      = store_reg;
        rem_next        = rem_reg;
        dsh_next        = dsh_reg;
        quo_next        = quo_reg;
        count_next      = count_reg;
        seen_full_next  = seen_full_reg;
        seen_empty_next = seen_empty_reg;
        chg_next        = chg_reg;
        in_ready        = 1'b0;
        res_valid       = 1'b0;
        alu_a           = '0;
        alu_b           = '0;
        alu_sub         = 1'b0;

        res.soc         = soc;
        res.soh         = soh_of(count_reg);
        res.charging    = chg_reg;
        res.half_cycles = count_reg;
        res.cycle_event = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (cfg.reload)
                    store_next = {2'b00, cfg.cap_units[UnitsW-1:1]};
                if (in_valid)
                begin
                    pos_next   = cur_s > thr_s;
                    neg_next   = in_cur[CurW-1];
                    if (cur_s > thr_s)
                        chg_next = 1'b1;
                    else if (cur_s < -thr_s)
                        chg_next = 1'b0;
                    mcand_next = {{(MagW-CurW){1'b0}}, cur_abs};
                    hi_next    = '0;
                    lo_next    = in_ms;
                    step_next  = '0;
                    state_next = ST_MUL_TIME;
                end
            end
            ST_MUL_TIME, ST_MUL_EFF:
            begin
                alu_a     = {{(AluW-HiW){1'b0}}, hi_reg};
                alu_b     = lo_reg[0] ? {{(AluW-MagW){1'b0}}, mcand_reg} : '0;
                hi_next   = mul_hi;
                lo_next   = mul_lo;
                step_next = step_reg + StepW'(1);
                if (step_reg == MUL_LAST)
                begin
                    step_next = '0;
                    if (state_reg == ST_MUL_EFF)
                    begin
                        // drop the 16 fraction bits of the efficiency product
                        mcand_next = mul_hi[MagW-1:0];
                        state_next = ST_ADD;
                    end
                    else
                    begin
                        mcand_next = {mul_hi[MagW-MsW-1:0], mul_lo};
                        if (pos_reg)
                        begin
                            hi_next    = '0;
                            lo_next    = cfg.eff;
                            state_next = ST_MUL_EFF;
                        end
                        else
                            state_next = ST_ADD;
                    end
                end
            end
            ST_ADD:
            begin
                alu_a   = {1'b0, store_reg};
                alu_b   = {{(AluW-MagW){1'b0}}, mcand_reg};
                alu_sub = neg_reg;
                if (neg_reg && !alu_carry)
                    store_next = '0;
                else
                    store_next = alu_res[StoreW-1:0];
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                alu_a      = {1'b0, store_reg};
                alu_b      = {{(AluW-UnitsW){1'b0}}, cfg.cap_units};
                alu_sub    = 1'b1;
                store_next = clamped;
                rem_next   = clamped;
                dsh_next   = {{(StoreW-DivW-DivSteps+1){1'b0}}, cfg.divisor, {(DivSteps-1){1'b0}}};
                quo_next   = '0;
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                alu_a     = {1'b0, rem_reg};
                alu_b     = {1'b0, dsh_reg};
                alu_sub   = 1'b1;
                if (alu_carry)
                    rem_next = alu_res[StoreW-1:0];
                quo_next  = {quo_reg[SocW-2:0], alu_carry};
                dsh_next  = {1'b0, dsh_reg[StoreW-1:1]};
                step_next = step_reg + StepW'(1);
                if (step_reg == DIV_LAST)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                res_valid = 1'b1;
                if (sf && se)
                begin
                    if (count_reg != '1)
                        count_next = count_reg + CntW'(1);
                    seen_full_next  = 1'b0;
                    seen_empty_next = 1'b0;
                    res.cycle_event = 1'b1;
                end
                else
                begin
                    seen_full_next  = sf;
                    seen_empty_next = se;
                end
                res.soh         = soh_of(count_next);
                res.half_cycles = count_next;
                if (res_ready)
                    state_next = ST_IDLE;
                else
                begin
                    // hold until the output register frees; marks commit with the result
                    count_next      = count_reg;
                    seen_full_next  = seen_full_reg;
                    seen_empty_next = seen_empty_reg;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

endmodule

// ----- design/ccs_checker.sv -----
// Port-level assertions for the coulomb counter, bound to the top level.
// Depends only on the top level's ports.
module ccs_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata
);

    logic [18:0] soh_dec;
    logic [18:0] soh_exp;

    assign soh_dec = {1'b0, m_tdata[44:29], 2'b00} + {3'b000, m_tdata[44:29]};
    assign soh_exp = (soh_dec >= 19'd10000) ? 19'd0 : (19'd10000 - soh_dec);

    // stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // a request keeps the block busy in the next cycle
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken on consecutive cycles");

    // health follows the half-cycle count in the same result
    a_soh: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> {5'b00000, m_tdata[27:14]} == soh_exp)
        else $error("health does not match half-cycle count");

    // charge never reported above full scale
    a_soc: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[13:0] <= 14'd10000)
        else $error("state of charge above full scale");

endmodule

bind coulomb_counter_soc_soh ccs_checker u_ccs_checker (.*);
